// File: rtl/ecev_pkg.sv
// Package for the easing curve evaluator.
// Widths, Q30 constants, curve codes and shared arithmetic helpers.
// No dependencies.
package ecev_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SPAN_W    = 16;
    localparam int PROG_W    = 17;
    localparam int PROG_FRAC = 16;
    localparam int OUT_W     = 17;
    localparam int SEL_W     = 4;

    localparam int Q_BITS    = 30;
    localparam int Q30_W     = 34;
    localparam int PQ_SHIFT  = Q_BITS - PROG_FRAC;

    localparam int CV_SHIFT  = Q_BITS - FRAC_BITS;
    localparam int CV_W      = FRAC_BITS + 2;
    localparam int PROD_W    = SPAN_W + CV_W;

    localparam int SINE_STEPS = 5;
    localparam int SINE_LAT   = 4 + 3 * SINE_STEPS;
    localparam int SQRT_STEPS = Q_BITS + 1;
    localparam int SQRT_LAT   = 1 + SQRT_STEPS;
    localparam int POLY_LAT   = 3;
    localparam int LAT_CURVE  = SQRT_LAT;

    localparam int ROOT_W   = 2 * Q_BITS + 2;
    localparam int SQ_SHIFT = 2 * Q_BITS - 2 * PROG_FRAC;

    typedef logic signed [Q30_W-1:0] q30_t;
    typedef logic [Q_BITS:0]         uq30_t;

    localparam logic [PROG_W-1:0] PROG_ONE = PROG_W'(1) << PROG_FRAC;
    localparam q30_t  ONE_Q30     = q30_t'(1) <<< Q_BITS;
    localparam uq30_t ONE_U       = uq30_t'(1) << Q_BITS;
    localparam uq30_t HALF_PI_Q30 = 31'd1686629713;
    localparam q30_t  BACK_S_Q30  = 34'sd1827057613;
    localparam q30_t  BACK_S1_Q30 = 34'sd2900799437;

    typedef enum logic [SEL_W-1:0] {
        CURVE_LINEAR      = 4'd0,
        CURVE_SINE_IN_OUT = 4'd1,
        CURVE_HALF_SINE   = 4'd2,
        CURVE_OUT_BACK    = 4'd3,
        CURVE_CIRC_IN     = 4'd4,
        CURVE_CIRC_OUT    = 4'd5,
        CURVE_CUBIC_IN    = 4'd6,
        CURVE_CUBIC_OUT   = 4'd7,
        CURVE_QUINT_IN    = 4'd8,
        CURVE_QUINT_OUT   = 4'd9
    } curve_t;

    // Horner divisors of the sine series and floor(2^34 / d)
    function automatic logic [6:0] sine_div(input int idx);
        logic [6:0] d;
        case (idx)
            0:       d = 7'd110;
            1:       d = 7'd72;
            2:       d = 7'd42;
            3:       d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] sine_recip(input int idx);
        logic [31:0] m;
        case (idx)
            0:       m = 32'd156180628;
            1:       m = 32'd238609294;
            2:       m = 32'd409044504;
            3:       m = 32'd858993459;
            default: m = 32'd2863311530;
        endcase
        return m;
    endfunction

    // Q30 product, rounded half up
    function automatic q30_t mul_q30(input q30_t a, input q30_t b);
        logic signed [2*Q30_W-1:0] pr;
        pr = a * b;
        pr = pr + ((2*Q30_W)'(1) <<< (Q_BITS - 1));
        return q30_t'(pr >>> Q_BITS);
    endfunction

endpackage

// File: rtl/ecev_sample_if.sv
// Input channel of the easing curve evaluator: span and progress.
// Depends on ecev_pkg.
interface ecev_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ecev_pkg::SPAN_W-1:0]   span;
    logic        [ecev_pkg::PROG_W-1:0]   progress;

    modport source (output valid, output span, output progress, input ready);
    modport sink   (input valid, input span, input progress, output ready);
endinterface

// File: rtl/ecev_result_if.sv
// Output channel of the easing curve evaluator: eased value.
// Depends on ecev_pkg.
interface ecev_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [ecev_pkg::OUT_W-1:0]   eased_value;

    modport source (output valid, output eased_value, input ready);
    modport sink   (input valid, input eased_value, output ready);
endinterface

// File: rtl/ecev_sine.sv
// Pipelined quarter-wave sine sin(p*pi/2) and its square, both in Q30.
// Output padded to line up with the ecev_sqrt pipeline. Depends on ecev_pkg.
module ecev_sine (
    input  logic                          clk,
    input  logic                          en,
    input  logic [ecev_pkg::PROG_W-1:0]   p,
    output ecev_pkg::uq30_t               sine,
    output ecev_pkg::uq30_t               sine_sq
);

    localparam int PAD = ecev_pkg::LAT_CURVE - ecev_pkg::SINE_LAT;
    localparam int XW  = ecev_pkg::Q_BITS + 1;
    localparam int P0W = ecev_pkg::PROG_W + XW;

    logic [P0W-1:0]  x_prod;
    logic [2*XW-1:0] x2_prod;
    logic [XW-1:0]   x_reg;
    logic [XW-1:0]   x1_reg;
    logic [31:0]     x2_reg;

    assign x_prod  = P0W'(p) * P0W'(ecev_pkg::HALF_PI_Q30);
    assign x2_prod = (2*XW)'(x_reg) * (2*XW)'(x_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= x_prod[ecev_pkg::PROG_FRAC +: XW];
            x1_reg <= x_reg;
            x2_reg <= x2_prod[ecev_pkg::Q_BITS +: 32];
        end
    end

    logic [XW-1:0]   x_step  [0:ecev_pkg::SINE_STEPS];
    logic [31:0]     x2_step [0:ecev_pkg::SINE_STEPS];
    ecev_pkg::uq30_t r_step  [0:ecev_pkg::SINE_STEPS];

    assign x_step[0]  = x1_reg;
    assign x2_step[0] = x2_reg;
    assign r_step[0]  = ecev_pkg::ONE_U;

    for (genvar k = 0; k < ecev_pkg::SINE_STEPS; k++)
    begin : g_step
        localparam logic [6:0]  D = ecev_pkg::sine_div(k);
        localparam logic [31:0] M = ecev_pkg::sine_recip(k);

        logic [XW-1:0]   a_x_reg, b_x_reg, c_x_reg;
        logic [31:0]     a_x2_reg, b_x2_reg, c_x2_reg;
        logic [31:0]     a_n_reg, b_n_reg;
        logic [29:0]     b_q0_reg;
        ecev_pkg::uq30_t c_r_reg;
        logic [62:0]     n_prod;
        logic [63:0]     q_prod;
        logic [31:0]     rem;
        logic [31:0]     q;

        assign n_prod = 63'(x2_step[k]) * 63'(r_step[k]);
        assign q_prod = 64'(a_n_reg) * 64'(M);
        assign rem    = b_n_reg - 32'(39'(b_q0_reg) * 39'(D));
        assign q      = 32'(b_q0_reg) + ((rem >= 32'(D)) ? 32'd1 : 32'd0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_x_reg  <= x_step[k];
                a_x2_reg <= x2_step[k];
                a_n_reg  <= n_prod[ecev_pkg::Q_BITS +: 32];
                b_x_reg  <= a_x_reg;
                b_x2_reg <= a_x2_reg;
                b_n_reg  <= a_n_reg;
                b_q0_reg <= q_prod[34 +: 30];
                c_x_reg  <= b_x_reg;
                c_x2_reg <= b_x2_reg;
                c_r_reg  <= XW'(32'(ecev_pkg::ONE_U) - q);
            end
        end

        assign x_step[k+1]  = c_x_reg;
        assign x2_step[k+1] = c_x2_reg;
        assign r_step[k+1]  = c_r_reg;
    end

    logic [2*XW-1:0]  s_prod;
    logic [31:0]      s_raw;
    ecev_pkg::uq30_t  s_reg;
    ecev_pkg::uq30_t  g_s_reg;
    ecev_pkg::uq30_t  g_sq_reg;
    logic [2*XW-1:0]  sq_prod;

    assign s_prod  = (2*XW)'(x_step[ecev_pkg::SINE_STEPS])
                   * (2*XW)'(r_step[ecev_pkg::SINE_STEPS]);
    assign s_raw   = s_prod[ecev_pkg::Q_BITS +: 32];
    assign sq_prod = (2*XW)'(s_reg) * (2*XW)'(s_reg)
                   + ((2*XW)'(1) << (ecev_pkg::Q_BITS - 1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= (s_raw > 32'(ecev_pkg::ONE_U)) ? ecev_pkg::ONE_U : XW'(s_raw);
            g_s_reg  <= s_reg;
            g_sq_reg <= sq_prod[ecev_pkg::Q_BITS +: XW];
        end
    end

    ecev_pkg::uq30_t pad_s_reg  [0:PAD-1];
    ecev_pkg::uq30_t pad_sq_reg [0:PAD-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pad_s_reg[0]  <= g_s_reg;
            pad_sq_reg[0] <= g_sq_reg;
            for (int i = 1; i < PAD; i++)
            begin
                pad_s_reg[i]  <= pad_s_reg[i-1];
                pad_sq_reg[i] <= pad_sq_reg[i-1];
            end
        end
    end

    assign sine    = pad_s_reg[PAD-1];
    assign sine_sq = pad_sq_reg[PAD-1];

endmodule

// File: rtl/ecev_sqrt.sv
// Pipelined floor square root of (1 - d^2) scaled to Q60, one result bit a stage.
// Q30 root taken from the last stage register. Depends on ecev_pkg.
module ecev_sqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [ecev_pkg::PROG_W-1:0]   d,
    output ecev_pkg::uq30_t               root
);

    localparam int RW = ecev_pkg::ROOT_W;
    localparam int N  = ecev_pkg::SQRT_STEPS;

    logic [RW-1:0] rem0;
    logic [RW-1:0] v_reg    [0:N];
    logic [RW-1:0] res_reg  [0:N];
    logic [RW-1:0] v_next   [1:N];
    logic [RW-1:0] res_next [1:N];

    assign rem0 = ((RW'(ecev_pkg::PROG_ONE) * RW'(ecev_pkg::PROG_ONE)) - RW'(d) * RW'(d))
                  << ecev_pkg::SQ_SHIFT;

    always_comb
    begin
        for (int k = 1; k <= N; k++)
        begin
            if (v_reg[k-1] >= res_reg[k-1] + (RW'(1) << (2 * (N - k))))
            begin
                v_next[k]   = v_reg[k-1] - (res_reg[k-1] + (RW'(1) << (2 * (N - k))));
                res_next[k] = (res_reg[k-1] >> 1) + (RW'(1) << (2 * (N - k)));
            end
            else
            begin
                v_next[k]   = v_reg[k-1];
                res_next[k] = res_reg[k-1] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0]   <= rem0;
            res_reg[0] <= '0;
            for (int k = 1; k <= N; k++)
            begin
                v_reg[k]   <= v_next[k];
                res_reg[k] <= res_next[k];
            end
        end
    end

    assign root = res_reg[N][ecev_pkg::Q_BITS:0];

endmodule

// File: rtl/easing_curve_evaluator_core.sv
// Top level of the easing curve evaluator: curve pipelines, scaling, saturation.
// Depends on ecev_pkg, ecev_sample_if, ecev_result_if, ecev_sine, ecev_sqrt.
//
// Scales a signed span by one of ten easing curves at a Q1.16 progress point and
// rounds the result to a saturated 17-bit integer. One transfer is accepted every
// cycle unless the output stalls; the square root stages of the circular curves
// set the pipeline length. The whole pipeline holds while a finished result waits,
// so back-pressure reaches the input at once. The user must write curve_select
// via cfg_we/cfg_wdata while the pipeline is empty; the block does not enforce it.
module easing_curve_evaluator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ecev_pkg::SEL_W-1:0]    cfg_wdata,
    ecev_sample_if.sink                   sample,
    ecev_result_if.source                 result
);

    localparam int L = ecev_pkg::LAT_CURVE;
    localparam int PP = L - ecev_pkg::POLY_LAT;

    logic [ecev_pkg::SEL_W-1:0] curve_select_reg;
    logic                       en;
    logic                       out_vld_reg;

    assign en           = !out_vld_reg || result.ready;
    assign sample.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            curve_select_reg <= ecev_pkg::CURVE_LINEAR;
        else if (cfg_we)
            curve_select_reg <= cfg_wdata;
    end

    logic [ecev_pkg::PROG_W-1:0] p;
    logic [ecev_pkg::PROG_W-1:0] d;
    assign p = (sample.progress > ecev_pkg::PROG_ONE) ? ecev_pkg::PROG_ONE : sample.progress;
    assign d = (curve_select_reg == ecev_pkg::CURVE_CIRC_IN) ? p : ecev_pkg::PROG_ONE - p;

    // control and span line
    logic                              vld_reg  [0:L-1];
    logic [ecev_pkg::SEL_W-1:0]        sel_reg  [0:L-1];
    logic signed [ecev_pkg::SPAN_W-1:0] span_reg [0:L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < L; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= sample.valid;
            for (int i = 1; i < L; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_reg[0]  <= curve_select_reg;
            span_reg[0] <= sample.span;
            for (int i = 1; i < L; i++)
            begin
                sel_reg[i]  <= sel_reg[i-1];
                span_reg[i] <= span_reg[i-1];
            end
        end
    end

    ecev_pkg::uq30_t sine, sine_sq, root;

    ecev_sine u_sine (
        .clk     (clk),
        .en      (en),
        .p       (p),
        .sine    (sine),
        .sine_sq (sine_sq)
    );

    ecev_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .d    (d),
        .root (root)
    );

    // polynomial curves and linear: Q30 multiplies spread over registered stages
    ecev_pkg::q30_t pq, t, x_op;
    ecev_pkg::q30_t m1_reg, a_reg, x1_reg, pq1_reg;
    ecev_pkg::q30_t m2_reg, x2_reg, pq2_reg;
    ecev_pkg::q30_t c3_reg;
    ecev_pkg::q30_t m2_op, c3_next;
    logic           quint2, quint3;

    assign pq   = ecev_pkg::q30_t'(p) <<< ecev_pkg::PQ_SHIFT;
    assign t    = pq - ecev_pkg::ONE_Q30;
    assign x_op = (curve_select_reg == ecev_pkg::CURVE_CUBIC_IN
                || curve_select_reg == ecev_pkg::CURVE_QUINT_IN) ? pq : t;

    assign quint2 = (sel_reg[0] == ecev_pkg::CURVE_QUINT_IN)
                 || (sel_reg[0] == ecev_pkg::CURVE_QUINT_OUT);
    assign quint3 = (sel_reg[1] == ecev_pkg::CURVE_QUINT_IN)
                 || (sel_reg[1] == ecev_pkg::CURVE_QUINT_OUT);
    assign m2_op  = quint2 ? m1_reg
                  : (sel_reg[0] == ecev_pkg::CURVE_OUT_BACK) ? a_reg : x1_reg;

    always_comb
    begin
        c3_next = quint3 ? ecev_pkg::mul_q30(m2_reg, x2_reg) : m2_reg;
        case (sel_reg[1])
            ecev_pkg::CURVE_OUT_BACK,
            ecev_pkg::CURVE_CUBIC_OUT,
            ecev_pkg::CURVE_QUINT_OUT: c3_next = c3_next + ecev_pkg::ONE_Q30;
            ecev_pkg::CURVE_CUBIC_IN,
            ecev_pkg::CURVE_QUINT_IN:  c3_next = c3_next;
            default:                   c3_next = pq2_reg;
        endcase
    end

    ecev_pkg::q30_t pad_reg [0:PP-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg  <= ecev_pkg::mul_q30(x_op, x_op);
            a_reg   <= ecev_pkg::mul_q30(ecev_pkg::BACK_S1_Q30, t) + ecev_pkg::BACK_S_Q30;
            x1_reg  <= x_op;
            pq1_reg <= pq;
            m2_reg  <= ecev_pkg::mul_q30(m1_reg, m2_op);
            x2_reg  <= x1_reg;
            pq2_reg <= pq1_reg;
            c3_reg  <= c3_next;
            pad_reg[0] <= c3_reg;
            for (int i = 1; i < PP; i++)
                pad_reg[i] <= pad_reg[i-1];
        end
    end

    // curve select, round to Q2.FRAC_BITS and saturate
    ecev_pkg::q30_t                       curve;
    logic signed [ecev_pkg::Q30_W:0]      cv_round;
    logic signed [ecev_pkg::Q30_W:0]      cv_shift;
    logic signed [ecev_pkg::CV_W-1:0]     cv_sat;
    logic signed [ecev_pkg::CV_W-1:0]     cv_reg;
    logic signed [ecev_pkg::SPAN_W-1:0]   span_cv_reg;
    logic                                 vld_cv_reg;
    logic signed [ecev_pkg::PROD_W-1:0]   prod_reg;
    logic                                 vld_prod_reg;
    logic signed [ecev_pkg::PROD_W:0]     prod_round;
    logic signed [ecev_pkg::PROD_W:0]     prod_shift;
    logic signed [ecev_pkg::OUT_W-1:0]    eased_next;
    logic signed [ecev_pkg::OUT_W-1:0]    eased_reg;

    localparam logic signed [ecev_pkg::Q30_W:0] CV_MAX =
        ((ecev_pkg::Q30_W+1)'(1) <<< (ecev_pkg::FRAC_BITS + 1)) - 1;
    localparam logic signed [ecev_pkg::Q30_W:0] CV_MIN =
        -((ecev_pkg::Q30_W+1)'(1) <<< (ecev_pkg::FRAC_BITS + 1));
    localparam logic signed [ecev_pkg::PROD_W:0] OUT_MAX =
        ((ecev_pkg::PROD_W+1)'(1) <<< (ecev_pkg::OUT_W - 1)) - 1;
    localparam logic signed [ecev_pkg::PROD_W:0] OUT_MIN =
        -((ecev_pkg::PROD_W+1)'(1) <<< (ecev_pkg::OUT_W - 1));

    always_comb
    begin
        case (sel_reg[L-1])
            ecev_pkg::CURVE_SINE_IN_OUT: curve = ecev_pkg::q30_t'(sine_sq);
            ecev_pkg::CURVE_HALF_SINE:   curve = ecev_pkg::q30_t'(sine);
            ecev_pkg::CURVE_CIRC_IN:     curve = ecev_pkg::ONE_Q30 - ecev_pkg::q30_t'(root);
            ecev_pkg::CURVE_CIRC_OUT:    curve = ecev_pkg::q30_t'(root);
            default:                     curve = pad_reg[PP-1];
        endcase
        cv_round = (ecev_pkg::Q30_W+1)'(curve)
                 + ((ecev_pkg::Q30_W+1)'(1) <<< (ecev_pkg::CV_SHIFT - 1));
        cv_shift = cv_round >>> ecev_pkg::CV_SHIFT;
        if (cv_shift > CV_MAX)
            cv_sat = ecev_pkg::CV_W'(CV_MAX);
        else if (cv_shift < CV_MIN)
            cv_sat = ecev_pkg::CV_W'(CV_MIN);
        else
            cv_sat = ecev_pkg::CV_W'(cv_shift);

        prod_round = (ecev_pkg::PROD_W+1)'(prod_reg)
                   + ((ecev_pkg::PROD_W+1)'(1) <<< (ecev_pkg::FRAC_BITS - 1));
        prod_shift = prod_round >>> ecev_pkg::FRAC_BITS;
        if (prod_shift > OUT_MAX)
            eased_next = ecev_pkg::OUT_W'(OUT_MAX);
        else if (prod_shift < OUT_MIN)
            eased_next = ecev_pkg::OUT_W'(OUT_MIN);
        else
            eased_next = ecev_pkg::OUT_W'(prod_shift);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_cv_reg   <= 1'b0;
            vld_prod_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            vld_cv_reg   <= vld_reg[L-1];
            vld_prod_reg <= vld_cv_reg;
            out_vld_reg  <= vld_prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cv_reg      <= cv_sat;
            span_cv_reg <= span_reg[L-1];
            prod_reg    <= ecev_pkg::PROD_W'(span_cv_reg) * ecev_pkg::PROD_W'(cv_reg);
            eased_reg   <= eased_next;
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.eased_value = eased_reg;

endmodule
